[rtl/core/orc_pkg.sv]
// Shared types, codes and constants of the obstacle range compensator.
package orc_pkg;

   localparam logic [15:0] OUTLIER_LIMIT_MM = 16'd5000;
   localparam logic signed [17:0] CORR_MAX = 18'sd8191;
   localparam logic signed [17:0] CORR_MIN = -18'sd8192;

   typedef enum logic [1:0] {
      STATUS_DROPPED = 2'd0,
      STATUS_SKIPPED = 2'd1,
      STATUS_SENT    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_TARGET_HEIGHT   = 3'd0,
      REG_OBSTACLE_HEIGHT = 3'd1,
      REG_EXIT_OFFSET     = 3'd2,
      REG_X_HALF_SIZE     = 3'd3,
      REG_Y_HALF_SIZE     = 3'd4,
      REG_XY_MARGIN       = 3'd5,
      REG_Z_MARGIN        = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [11:0] target_height;
      logic [11:0] obstacle_height;
      logic [11:0] exit_offset;
      logic [11:0] x_half_size;
      logic [11:0] y_half_size;
      logic [11:0] xy_margin;
      logic [11:0] z_margin;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      target_height:   12'd500,
      obstacle_height: 12'd300,
      exit_offset:     12'd20,
      x_half_size:     12'd260,
      y_half_size:     12'd120,
      xy_margin:       12'd80,
      z_margin:        12'd50
   };

   typedef struct packed {
      logic signed [15:0] pos_y_mm;
      logic signed [15:0] pos_x_mm;
      logic [15:0]        range_mm;
   } sample_type;

   typedef struct packed {
      logic outside_xy;
      logic outside_z;
   } flags_type;

   typedef struct packed {
      status_type         status;
      logic               flag_outside_z;
      logic               flag_outside_xy;
      logic signed [13:0] corrected_range;
      logic [15:0]        raw_range;
   } result_type;

endpackage

[rtl/core/orc_csr.sv]
// Configuration register file of the obstacle range compensator.
module orc_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_addr,
   input  logic [11:0]           csr_wdata,
   output orc_pkg::cfg_type      cfg
);
   import orc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            REG_TARGET_HEIGHT:   cfg_in.target_height = csr_wdata;
            REG_OBSTACLE_HEIGHT: cfg_in.obstacle_height = csr_wdata;
            REG_EXIT_OFFSET:     cfg_in.exit_offset = csr_wdata;
            REG_X_HALF_SIZE:     cfg_in.x_half_size = csr_wdata;
            REG_Y_HALF_SIZE:     cfg_in.y_half_size = csr_wdata;
            REG_XY_MARGIN:       cfg_in.xy_margin = csr_wdata;
            REG_Z_MARGIN:        cfg_in.z_margin = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/orc_calc.sv]
// Hysteresis update, border test and range correction for one sample.
module orc_calc (
   input  orc_pkg::sample_type  sample,
   input  orc_pkg::cfg_type     cfg,
   input  orc_pkg::flags_type   flags,
   output orc_pkg::flags_type   flags_next,
   output orc_pkg::result_type  result
);
   import orc_pkg::*;

   function automatic logic [15:0] abs_sat(input logic signed [15:0] v);
      logic [15:0] neg;
      neg = 16'(-v);
      if (!v[15]) begin
         abs_sat = 16'(v);
      end else if (v == 16'sh8000) begin
         abs_sat = 16'h7FFF;
      end else begin
         abs_sat = neg;
      end
   endfunction

   logic [15:0]        ax;
   logic [15:0]        ay;
   logic [15:0]        x_lo;
   logic [15:0]        y_lo;
   logic [15:0]        x_hi;
   logic [15:0]        y_hi;
   logic               in_range;
   logic               border;
   logic signed [17:0] range_s;
   logic signed [17:0] base;
   logic signed [17:0] base_hi;
   logic signed [17:0] corr_full;
   logic [13:0]        corr_sat;

   assign ax = abs_sat(sample.pos_x_mm);
   assign ay = abs_sat(sample.pos_y_mm);
   assign x_lo = 16'(cfg.x_half_size);
   assign y_lo = 16'(cfg.y_half_size);
   assign x_hi = x_lo + 16'(cfg.xy_margin);
   assign y_hi = y_lo + 16'(cfg.xy_margin);

   assign in_range = sample.range_mm < OUTLIER_LIMIT_MM;
   assign range_s = $signed({2'b00, sample.range_mm});
   assign base = $signed(18'(cfg.target_height)) + $signed(18'(cfg.obstacle_height))
               - $signed(18'(cfg.exit_offset));
   assign base_hi = base + $signed(18'(cfg.z_margin));

   always_comb begin
      flags_next = flags;
      if (in_range) begin
         if (flags.outside_xy) begin
            if (ax < x_lo && ay < y_lo) begin
               flags_next.outside_xy = 1'b0;
            end
         end else if (ax > x_hi || ay > y_hi) begin
            flags_next.outside_xy = 1'b1;
         end
         if (flags.outside_z) begin
            if (range_s < base) begin
               flags_next.outside_z = 1'b0;
            end
         end else if (range_s > base_hi) begin
            flags_next.outside_z = 1'b1;
         end
      end
   end

   assign corr_full = (flags_next.outside_xy && flags_next.outside_z)
                    ? range_s - $signed(18'(cfg.obstacle_height)) : range_s;

   always_comb begin
      if (corr_full > CORR_MAX) begin
         corr_sat = CORR_MAX[13:0];
      end else if (corr_full < CORR_MIN) begin
         corr_sat = CORR_MIN[13:0];
      end else begin
         corr_sat = corr_full[13:0];
      end
   end

   assign border = (ax >= x_lo && ax <= x_hi) || (ay >= y_lo && ay <= y_hi);

   always_comb begin
      result.raw_range = sample.range_mm;
      result.flag_outside_xy = flags_next.outside_xy;
      result.flag_outside_z = flags_next.outside_z;
      if (!in_range) begin
         result.status = STATUS_DROPPED;
         result.corrected_range = '0;
      end else begin
         result.status = border ? STATUS_SKIPPED : STATUS_SENT;
         result.corrected_range = $signed(corr_sat);
      end
   end

endmodule

[rtl/core/obstacle_range_compensator.sv]
// Top level of the obstacle range compensator: input and result registers and flag state.
//
// Each transaction on the req_ channel carries one range sample and the X and Y
// position; each yields exactly one transaction on the rsp_ channel with the
// status in rsp_tuser and the raw range, corrected range and both hysteresis
// flags in rsp_tdata. A sample at or above the outlier limit is returned with
// status dropped and leaves the flags unchanged.
// The sample is captured in an input register, the flags and correction are
// computed combinationally from it, and the result is held in an output
// register that drives rsp_. One sample is taken every cycle while the
// receiver keeps rsp_tready high; the flag update is the only loop and it
// passes only through the flag register.
// When the receiver stalls, the output register holds its result and the input
// register holds the next sample; req_tready falls once both are full.
// Reset clears both flags, empties both registers and loads the default
// configuration. The csr_ channel is always ready and should only be written
// while no sample is in flight.
module obstacle_range_compensator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // range_mm[15:0], pos_x_mm[31:16], pos_y_mm[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // raw_range[15:0], corrected_range[29:16],
                                    // flag_outside_xy[30], flag_outside_z[31]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [11:0] csr_wdata
);
   import orc_pkg::*;

   cfg_type    cfg;
   flags_type  flags_ff;
   flags_type  flags_in;
   flags_type  flags_calc;
   result_type calc_res;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   sample_type s1_sample_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;
   logic       out_ready;
   logic       s1_advance;
   logic       req_accept;

   orc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   orc_calc u_calc (
      .sample     (s1_sample_ff),
      .cfg        (cfg),
      .flags      (flags_ff),
      .flags_next (flags_calc),
      .result     (calc_res)
   );

   assign out_ready = !out_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);
   assign out_valid_in = s1_advance || (out_valid_ff && !rsp_tready);
   assign flags_in = s1_advance ? flags_calc : flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_tdata;
      end
      if (s1_advance) begin
         out_res_ff <= calc_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {out_res_ff.flag_outside_z, out_res_ff.flag_outside_xy,
                       out_res_ff.corrected_range, out_res_ff.raw_range};
   assign rsp_tuser = out_res_ff.status;

   // The flags on the output always match the current state while a result waits.
   a_flags_match: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_res_ff.flag_outside_xy == flags_ff.outside_xy &&
                        out_res_ff.flag_outside_z == flags_ff.outside_z))
      else $error("Result flags differ from flag state.");

   // A dropped sample leaves the flags unchanged.
   a_drop_keeps_flags: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && calc_res.status == STATUS_DROPPED) |=>
         ($stable(flags_ff.outside_xy) && $stable(flags_ff.outside_z)))
      else $error("Dropped sample changed the flags.");

   // A dropped sample reports a zero corrected range.
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.status == STATUS_DROPPED) |->
         (out_res_ff.corrected_range == '0))
      else $error("Dropped sample has a nonzero corrected range.");

   // The flags change only when a sample moves into the output register.
   a_flags_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !s1_advance |=> $stable(flags_ff))
      else $error("Flags changed without a sample.");

   // A full input register that cannot move on blocks new samples.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |-> !req_tready)
      else $error("Input register overrun.");

endmodule

[dv/obstacle_range_compensator_tb.sv]
// Self-checking testbench of the obstacle range compensator with a predicting scoreboard.
`timescale 1ns / 100ps

import orc_pkg::*;

class range_scoreboard;
   cfg_type    regs;
   logic       outside_xy;
   logic       outside_z;
   result_type expected_q[$];
   int         errors;

   function new();
      regs = CFG_RESET;
      outside_xy = 1'b0;
      outside_z = 1'b0;
      errors = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [11:0] value);
      case (idx)
         REG_TARGET_HEIGHT:   regs.target_height = value;
         REG_OBSTACLE_HEIGHT: regs.obstacle_height = value;
         REG_EXIT_OFFSET:     regs.exit_offset = value;
         REG_X_HALF_SIZE:     regs.x_half_size = value;
         REG_Y_HALF_SIZE:     regs.y_half_size = value;
         REG_XY_MARGIN:       regs.xy_margin = value;
         REG_Z_MARGIN:        regs.z_margin = value;
         default: ;
      endcase
   endfunction

   function int pos_mag(logic signed [15:0] pos);
      int v;
      v = int'(pos);
      if (v < 0) v = -v;
      if (v > 32767) v = 32767;
      return v;
   endfunction

   function void note_sample(sample_type s);
      int rng, ax, ay, xh, yh, margin, base, corr;
      logic border;
      result_type r;
      rng = int'(s.range_mm);
      ax = pos_mag(s.pos_x_mm);
      ay = pos_mag(s.pos_y_mm);
      xh = int'(regs.x_half_size);
      yh = int'(regs.y_half_size);
      margin = int'(regs.xy_margin);
      corr = 0;
      r.status = STATUS_DROPPED;
      if (rng < int'(OUTLIER_LIMIT_MM)) begin
         base = int'(regs.target_height) + int'(regs.obstacle_height)
                - int'(regs.exit_offset);
         if (outside_xy) begin
            if (ax < xh && ay < yh) outside_xy = 1'b0;
         end else begin
            if (ax > xh + margin || ay > yh + margin) outside_xy = 1'b1;
         end
         if (outside_z) begin
            if (rng < base) outside_z = 1'b0;
         end else begin
            if (rng > base + int'(regs.z_margin)) outside_z = 1'b1;
         end
         corr = rng;
         if (outside_xy && outside_z) corr = rng - int'(regs.obstacle_height);
         if (corr > int'(CORR_MAX)) corr = int'(CORR_MAX);
         if (corr < int'(CORR_MIN)) corr = int'(CORR_MIN);
         border = (ax >= xh && ax <= xh + margin) || (ay >= yh && ay <= yh + margin);
         r.status = border ? STATUS_SKIPPED : STATUS_SENT;
      end
      r.raw_range = s.range_mm;
      r.corrected_range = corr[13:0];
      r.flag_outside_xy = outside_xy;
      r.flag_outside_z = outside_z;
      expected_q.push_back(r);
   endfunction

   function void compare_field(string name, int exp_value, int act_value);
      if (exp_value != act_value) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_value, act_value);
         errors++;
      end
   endfunction

   function void check_result(logic [31:0] data, logic [1:0] user);
      result_type got;
      result_type exp;
      got = result_type'({user, data});
      if (expected_q.size() == 0) begin
         $error("unexpected result transaction with raw_range %0d", got.raw_range);
         errors++;
         return;
      end
      exp = expected_q.pop_front();
      compare_field("status", int'(exp.status), int'(got.status));
      compare_field("raw_range", int'(exp.raw_range), int'(got.raw_range));
      compare_field("corrected_range", int'(exp.corrected_range),
                    int'(got.corrected_range));
      compare_field("flag_outside_xy", int'(exp.flag_outside_xy),
                    int'(got.flag_outside_xy));
      compare_field("flag_outside_z", int'(exp.flag_outside_z), int'(got.flag_outside_z));
   endfunction
endclass

module obstacle_range_compensator_tb;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          NUM_PHASES = 10;
   localparam int          ITEMS_PER_PHASE = 140;
   localparam int          LONG_HOLD = 80;
   localparam logic [2:0]  REG_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_addr = '0;
   logic [11:0] csr_wdata = '0;

   range_scoreboard range_board = new();
   int   cycle_count = 0;
   logic tx_steady = 1'b0;
   logic rx_steady = 1'b0;
   logic long_hold_pending = 1'b0;

   obstacle_range_compensator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) range_board.check_result(rsp_tdata, rsp_tuser);
   end

   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin : rsp_drive
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_pending = 1'b0;
         end else if (rx_steady || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (idle_len()) @(posedge clock);
         end
      end
   end

   task automatic send_sample(input logic [15:0] rng, input logic signed [15:0] x,
                              input logic signed [15:0] y);
      sample_type s;
      s.range_mm = rng;
      s.pos_x_mm = x;
      s.pos_y_mm = y;
      req_tvalid <= 1'b1;
      req_tdata <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      range_board.note_sample(s);
      if (!tx_steady && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat (idle_len()) @(posedge clock);
      end
   endtask

   task automatic write_config(input cfg_type c);
      logic [11:0] vals[8];
      vals[REG_TARGET_HEIGHT] = c.target_height;
      vals[REG_OBSTACLE_HEIGHT] = c.obstacle_height;
      vals[REG_EXIT_OFFSET] = c.exit_offset;
      vals[REG_X_HALF_SIZE] = c.x_half_size;
      vals[REG_Y_HALF_SIZE] = c.y_half_size;
      vals[REG_XY_MARGIN] = c.xy_margin;
      vals[REG_Z_MARGIN] = c.z_margin;
      vals[REG_UNUSED] = 12'($urandom);
      csr_valid <= 1'b1;
      for (int i = 0; i < 8; i++) begin
         csr_addr <= i[2:0];
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         range_board.write_reg(i[2:0], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (range_board.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic cfg_type phase_config(int ph);
      cfg_type c;
      case (ph)
         1: c = '0;
         2: c = '1;
         3: c = '{target_height: 12'd0, obstacle_height: 12'd4095, exit_offset: 12'd4095,
                  x_half_size: 12'd0, y_half_size: 12'd0, xy_margin: 12'd0,
                  z_margin: 12'd0};
         NUM_PHASES - 1: c = CFG_RESET;
         default: begin
            c.target_height = 12'($urandom_range(0, 2500));
            c.obstacle_height = 12'($urandom_range(0, 1500));
            c.exit_offset = 12'($urandom_range(0, 400));
            c.x_half_size = 12'($urandom_range(0, 1500));
            c.y_half_size = 12'($urandom_range(0, 1500));
            c.xy_margin = 12'($urandom_range(0, 300));
            c.z_margin = 12'($urandom_range(0, 300));
            if ($urandom_range(0, 3) == 0) c.obstacle_height = 12'($urandom_range(0, 4095));
            if ($urandom_range(0, 3) == 0) c.exit_offset = 12'($urandom_range(0, 4095));
         end
      endcase
      return c;
   endfunction

   function automatic logic signed [15:0] near_edge(int half, int margin);
      int mag;
      if ($urandom_range(0, 3) == 0) mag = $urandom_range(0, 32767);
      else mag = half - 60 + int'($urandom_range(0, margin + 120));
      if (mag < 0) mag = 0;
      if (mag > 32767) mag = 32767;
      if ($urandom_range(0, 1) == 1) mag = -mag;
      return 16'(mag);
   endfunction

   task automatic random_item();
      int pick, base, rng;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         send_sample(16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         base = int'(range_board.regs.target_height) + int'(range_board.regs.obstacle_height)
                - int'(range_board.regs.exit_offset);
         if (pick < 13) rng = $urandom_range(int'(OUTLIER_LIMIT_MM), 65535);
         else if (pick < 28) rng = $urandom_range(0, int'(OUTLIER_LIMIT_MM) - 1);
         else begin
            rng = base - 100
                  + int'($urandom_range(0, int'(range_board.regs.z_margin) + 200));
            if (rng < 0) rng = 0;
            if (rng > int'(OUTLIER_LIMIT_MM) - 1) rng = int'(OUTLIER_LIMIT_MM) - 1;
         end
         send_sample(16'(rng),
                     near_edge(int'(range_board.regs.x_half_size),
                               int'(range_board.regs.xy_margin)),
                     near_edge(int'(range_board.regs.y_half_size),
                               int'(range_board.regs.xy_margin)));
      end
   endtask

   task automatic directed_items();
      send_sample(16'd0, 16'sd0, 16'sd0);
      send_sample(16'd4999, 16'sd0, 16'sd0);
      send_sample(16'd5000, 16'sd0, 16'sd0);
      send_sample(16'd65535, -16'sd1, -16'sd1);
      send_sample(16'd100, 16'sd32767, -16'sd32768);
      send_sample(16'd831, 16'sd500, 16'sd0);
      send_sample(16'd780, 16'sd340, 16'sd0);
      send_sample(16'd779, 16'sd260, 16'sd0);
      send_sample(16'd830, -16'sd259, 16'sd119);
      send_sample(16'd2000, 16'sd0, -16'sd200);
      send_sample(16'd2000, 16'sd0, -16'sd201);
      send_sample(16'd6000, 16'sd0, 16'sd0);
      send_sample(16'd4999, 16'sd0, 16'sd120);
      send_sample(16'd0, -16'sd32768, -16'sd32768);
      send_sample(16'hAAAA, 16'sh5555, 16'shAAAA);
      send_sample(16'h5555, 16'shAAAA, 16'sh5555);
      send_sample(16'd300, -16'sd260, -16'sd341);
      send_sample(16'd1, -16'sd32767, 16'sd32767);
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            wait_drained();
            write_config(phase_config(ph));
         end
         tx_steady = ($urandom_range(0, 2) == 0);
         rx_steady = ($urandom_range(0, 2) == 0);
         if (ph == 2 || ph == 6) begin
            tx_steady = 1'b1;
            long_hold_pending = 1'b1;
         end
         if (ph == 0) directed_items();
         repeat (ITEMS_PER_PHASE) random_item();
         req_tvalid <= 1'b0;
      end
      wait_drained();
      repeat (10) @(posedge clock);
      if (range_board.errors == 0 && range_board.expected_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/orc_pkg.sv
rtl/core/orc_csr.sv
rtl/core/orc_calc.sv
rtl/core/obstacle_range_compensator.sv
dv/obstacle_range_compensator_tb.sv
